@@ src/windowed_mean_square_six_channel_top_macros.svh @@
// Assertion macros for the windowed mean square block.
// Used by wmsq_ctrl and wmsq_lane; needs clk and rst in the including scope.
`ifndef WINDOWED_MEAN_SQUARE_SIX_CHANNEL_TOP_MACROS_SVH
`define WINDOWED_MEAN_SQUARE_SIX_CHANNEL_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define WMSQ_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define WMSQ_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define WMSQ_IMPLIES(lbl, ante, cons)

`define WMSQ_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/wmsq_pkg.sv @@
// Shared constants, types and register codes for the windowed mean square block.
// No dependencies.
`default_nettype none

package wmsq_pkg;

  localparam int CHANNELS   = 6;
  localparam int MAX_WINDOW = 1024;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 41;
  localparam int MEAN_W   = 31;
  localparam int LEN_W    = 11;
  localparam int INV_W    = 25;
  localparam int FRAC_W   = 24;
  localparam int HI_W     = SUM_W - FRAC_W;
  localparam int HIP_W    = HI_W + INV_W;
  localparam int LOP_W    = FRAC_W + INV_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WINDOW = 2'd1;

  localparam logic [LEN_W-1:0] WINDOW_LEN_RST = 11'd400;
  localparam logic [INV_W-1:0] INV_WINDOW_RST = 25'd41943;

  typedef logic [MEAN_W-1:0] mean_t;

  typedef struct packed {
    logic load1;
    logic load2;
    logic done2;
    logic load3;
    logic load4;
    logic done4;
  } ctl_t;

endpackage

`default_nettype wire

@@ src/windowed_mean_square_six_channel_top.sv @@
// Windowed mean square over six channels (three voltages, three currents).
// Result path: registered square, then sum and snapshot, then split products, then latched mean and out_valid.
// Throughput: one sample set per cycle while in_stall is low; lanes run in parallel, four register stages.
// Reset (rst, synchronous): sums, latched means, counter and valids clear;
// window_len returns to 400 and inv_window to 41943.
// Depends on wmsq_pkg, wmsq_ctrl and wmsq_lane.
`default_nettype none

module windowed_mean_square_six_channel_top #(
  parameter int MAX_WINDOW = wmsq_pkg::MAX_WINDOW
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [wmsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [wmsq_pkg::INV_W-1:0]      cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  signed [wmsq_pkg::SAMPLE_W-1:0] volt_a,
  input  wire  signed [wmsq_pkg::SAMPLE_W-1:0] volt_b,
  input  wire  signed [wmsq_pkg::SAMPLE_W-1:0] volt_c,
  input  wire  signed [wmsq_pkg::SAMPLE_W-1:0] curr_a,
  input  wire  signed [wmsq_pkg::SAMPLE_W-1:0] curr_b,
  input  wire  signed [wmsq_pkg::SAMPLE_W-1:0] curr_c,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [wmsq_pkg::MEAN_W-1:0]     ms_volt_a,
  output logic [wmsq_pkg::MEAN_W-1:0]     ms_volt_b,
  output logic [wmsq_pkg::MEAN_W-1:0]     ms_volt_c,
  output logic [wmsq_pkg::MEAN_W-1:0]     ms_curr_a,
  output logic [wmsq_pkg::MEAN_W-1:0]     ms_curr_b,
  output logic [wmsq_pkg::MEAN_W-1:0]     ms_curr_c,
  output logic                            window_done
);

  logic [wmsq_pkg::SAMPLE_W-1:0] samples [wmsq_pkg::CHANNELS];
  wmsq_pkg::mean_t               means   [wmsq_pkg::CHANNELS];
  logic [wmsq_pkg::INV_W-1:0]    inv_window;
  wmsq_pkg::ctl_t                ctl;

  assign samples[0] = volt_a;
  assign samples[1] = volt_b;
  assign samples[2] = volt_c;
  assign samples[3] = curr_a;
  assign samples[4] = curr_b;
  assign samples[5] = curr_c;

  wmsq_ctrl #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .window_done(window_done),
    .inv_window (inv_window),
    .ctl        (ctl)
  );

  for (genvar g = 0; g < wmsq_pkg::CHANNELS; g++) begin : g_lane
    wmsq_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sample    (samples[g]),
      .inv_window(inv_window),
      .ms        (means[g])
    );
  end

  // lane means merge onto the result ports
  assign ms_volt_a = means[0];
  assign ms_volt_b = means[1];
  assign ms_volt_c = means[2];
  assign ms_curr_a = means[3];
  assign ms_curr_b = means[4];
  assign ms_curr_c = means[5];

endmodule

`default_nettype wire

@@ src/wmsq_lane.sv @@
// One channel lane: square, windowed accumulate, reciprocal scale, latched mean.
// Depends on wmsq_pkg and the assertion macro header.
`default_nettype none

`include "windowed_mean_square_six_channel_top_macros.svh"

module wmsq_lane (
  input  wire                            clk,
  input  wire                            rst,
  input  wmsq_pkg::ctl_t                 ctl,
  input  wire  [wmsq_pkg::SAMPLE_W-1:0]  sample,
  input  wire  [wmsq_pkg::INV_W-1:0]     inv_window,
  output wmsq_pkg::mean_t                ms
);

  logic [wmsq_pkg::SAMPLE_W-1:0]  mag;
  logic [2*wmsq_pkg::SAMPLE_W-1:0] prod;
  logic [wmsq_pkg::SQ_W-1:0]      sq;
  logic [wmsq_pkg::SUM_W-1:0]     sum;
  logic [wmsq_pkg::SUM_W:0]       sum_ext;
  logic [wmsq_pkg::SUM_W-1:0]     sum_next;
  logic [wmsq_pkg::SUM_W-1:0]     snap;
  logic [wmsq_pkg::HIP_W-1:0]     hi_p;
  logic [wmsq_pkg::LOP_W-1:0]     lo_p;
  logic [wmsq_pkg::HIP_W:0]       mean_full;
  wmsq_pkg::mean_t                mean_next;

  assign mag  = sample[wmsq_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign prod = mag * mag;

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      sq <= prod[wmsq_pkg::SQ_W-1:0];
    end
  end

  // saturating accumulate
  assign sum_ext  = {1'b0, sum} + (wmsq_pkg::SUM_W + 1)'(sq);
  assign sum_next = sum_ext[wmsq_pkg::SUM_W] ? {wmsq_pkg::SUM_W{1'b1}}
                                             : sum_ext[wmsq_pkg::SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.load2) begin
      sum <= ctl.done2 ? wmsq_pkg::SUM_W'(sq) : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load2 && ctl.done2) begin
      snap <= sum;
    end
  end

  // split product keeps each multiplier under 32x32
  always_ff @(posedge clk) begin
    if (ctl.load3) begin
      hi_p <= snap[wmsq_pkg::SUM_W-1:wmsq_pkg::FRAC_W] * inv_window;
      lo_p <= snap[wmsq_pkg::FRAC_W-1:0] * inv_window;
    end
  end

  assign mean_full = {1'b0, hi_p}
                   + (wmsq_pkg::HIP_W + 1)'(lo_p[wmsq_pkg::LOP_W-1:wmsq_pkg::FRAC_W]);
  assign mean_next = (mean_full > (wmsq_pkg::HIP_W + 1)'({wmsq_pkg::MEAN_W{1'b1}}))
                   ? {wmsq_pkg::MEAN_W{1'b1}} : mean_full[wmsq_pkg::MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ms <= '0;
    end else if (ctl.load4 && ctl.done4) begin
      ms <= mean_next;
    end
  end

  `WMSQ_NEXT(a_sum_restart, ctl.load2 && ctl.done2, sum == wmsq_pkg::SUM_W'($past(sq)))
  `WMSQ_NEXT(a_sum_hold, !ctl.load2, sum == $past(sum))
  `WMSQ_NEXT(a_ms_hold, !(ctl.load4 && ctl.done4), ms == $past(ms))

endmodule

`default_nettype wire

@@ src/wmsq_ctrl.sv @@
// Control: configuration registers, sample counter, stage valids and handshakes.
// Depends on wmsq_pkg and the assertion macro header.
`default_nettype none

`include "windowed_mean_square_six_channel_top_macros.svh"

module wmsq_ctrl #(
  parameter int MAX_WINDOW = wmsq_pkg::MAX_WINDOW
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [wmsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [wmsq_pkg::INV_W-1:0]      cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            window_done,
  output logic [wmsq_pkg::INV_W-1:0]      inv_window,
  output wmsq_pkg::ctl_t                  ctl
);

  localparam int MaxW = $clog2(MAX_WINDOW + 1);
  localparam int EffW = (MaxW > wmsq_pkg::LEN_W) ? MaxW : wmsq_pkg::LEN_W;

  logic [wmsq_pkg::LEN_W-1:0] window_len;
  logic [wmsq_pkg::LEN_W-1:0] count;
  logic [wmsq_pkg::LEN_W-1:0] count_next;
  logic [EffW-1:0]            len_ext;
  logic [EffW-1:0]            eff_len;
  logic                       done0;
  logic                       v1, v2, v3;
  logic                       d1, d2, d3;
  logic                       rdy1, rdy2, rdy3, rdy4;
  logic                       acc, adv2, adv3, adv4;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= wmsq_pkg::WINDOW_LEN_RST;
      inv_window <= wmsq_pkg::INV_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wmsq_pkg::REG_WINDOW_LEN: window_len <= cfg_data[wmsq_pkg::LEN_W-1:0];
        wmsq_pkg::REG_INV_WINDOW: inv_window <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_ext = EffW'(window_len);
  assign eff_len = (len_ext > EffW'(MAX_WINDOW)) ? EffW'(MAX_WINDOW) : len_ext;
  assign done0   = EffW'(count) >= eff_len;

  // stage ready chain, bubbles collapse
  assign rdy4 = !out_valid || !out_stall;
  assign adv4 = v3 && rdy4;
  assign rdy3 = !v3 || rdy4;
  assign adv3 = v2 && rdy3;
  assign rdy2 = !v2 || rdy3;
  assign adv2 = v1 && rdy2;
  assign rdy1 = !v1 || rdy2;
  assign acc  = in_valid && rdy1;
  assign in_stall = !rdy1;

  assign count_next = done0 ? wmsq_pkg::LEN_W'(1) : count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        count <= count_next;
      end
      v1        <= acc  || (v1 && !adv2);
      v2        <= adv2 || (v2 && !adv3);
      v3        <= adv3 || (v3 && !adv4);
      out_valid <= adv4 || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      d1 <= done0;
    end
    if (adv2) begin
      d2 <= d1;
    end
    if (adv3) begin
      d3 <= d2;
    end
    if (adv4) begin
      window_done <= d3;
    end
  end

  assign ctl.load1 = acc;
  assign ctl.load2 = adv2;
  assign ctl.done2 = d1;
  assign ctl.load3 = adv3;
  assign ctl.load4 = adv4;
  assign ctl.done4 = d3;

  `WMSQ_NEXT(a_count_restart, acc && done0, count == wmsq_pkg::LEN_W'(1))
  `WMSQ_IMPLIES(a_take_when_empty, !v1, !in_stall)
  `WMSQ_NEXT(a_out_fill, adv4, out_valid)

endmodule

`default_nettype wire
